FILE: rtl/inverter_frame_codec_crc16_macros.svh
// Assertion macros for the inverter frame codec.
// Both macros sample on the rising edge of clk and are disabled while rst is high.
`ifndef INVERTER_FRAME_CODEC_CRC16_MACROS_SVH
`define INVERTER_FRAME_CODEC_CRC16_MACROS_SVH

`ifndef SYNTHESIS

`define IFC_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("codec check failed");

`define IFC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("codec check failed");

`else

`define IFC_ASSERT_SAME(lbl, pre, post)

`define IFC_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

FILE: rtl/ifc_pkg.sv
package ifc_pkg;

  localparam int FRAME_LEN = 10;
  localparam int CRC_LEN   = 8;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [7:0] CMD_CW    = 8'h14;
  localparam logic [7:0] CMD_CCW   = 8'h18;
  localparam logic [7:0] CMD_ACCEL = 8'hA0;
  localparam logic [7:0] REPLY_ACK = 8'h06;
  localparam logic [7:0] REPLY_NCK = 8'h15;

  localparam logic ACTION_SEND = 1'b0;
  localparam logic ACTION_RECV = 1'b1;

  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [1:0] {
    RK_ACK   = 2'd0,
    RK_NCK   = 2'd1,
    RK_OTHER = 2'd2
  } reply_kind_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } tx_word_t;

  typedef struct packed {
    logic        valid;
    logic        crc_ok;
    reply_kind_t reply_kind;
    logic [7:0]  echoed_mode;
    logic [15:0] motor_rpm;
    logic [7:0]  fault_code;
  } rx_report_t;

  // Nibble table for the reflected polynomial 0x8408.
  function automatic logic [15:0] nib_tab(input logic [3:0] n);
    logic [15:0] v;
    case (n)
      4'h0: v = 16'h0000;
      4'h1: v = 16'h1081;
      4'h2: v = 16'h2102;
      4'h3: v = 16'h3183;
      4'h4: v = 16'h4204;
      4'h5: v = 16'h5285;
      4'h6: v = 16'h6306;
      4'h7: v = 16'h7387;
      4'h8: v = 16'h8408;
      4'h9: v = 16'h9489;
      4'hA: v = 16'hA50A;
      4'hB: v = 16'hB58B;
      4'hC: v = 16'hC60C;
      4'hD: v = 16'hD68D;
      4'hE: v = 16'hE70E;
      4'hF: v = 16'hF78F;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

  // One byte through the CRC, low nibble first.
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] t;
    t = (c >> 4) ^ nib_tab(c[3:0] ^ b[3:0]);
    return (t >> 4) ^ nib_tab(t[3:0] ^ b[7:4]);
  endfunction

endpackage

FILE: rtl/ifc_tx.sv
module ifc_tx (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            advance,
  input  logic [7:0]      cmd_code,
  input  logic [15:0]     speed_value,
  input  logic [7:0]      accel_value,
  output ifc_pkg::tx_word_t word,
  output logic            busy
);
  import ifc_pkg::*;

  logic [3:0]  idx;
  logic [7:0]  b1;
  logic [7:0]  b2;
  logic [15:0] crc;
  logic [7:0]  b1_next;
  logic [7:0]  b2_next;
  logic [7:0]  cur_byte;
  logic [15:0] crc_inv;

  assign crc_inv = ~crc;

  always_comb begin
    b1_next = 8'h00;
    b2_next = 8'h00;
    if (cmd_code == CMD_CW || cmd_code == CMD_CCW) begin
      b1_next = speed_value[15:8];
      b2_next = speed_value[7:0];
    end else if (cmd_code == CMD_ACCEL) begin
      b1_next = accel_value;
    end
  end

  // Byte zero goes out in the accept cycle; the rest follow from the held frame.
  always_comb begin
    case (idx) inside
      4'd1:                   cur_byte = b1;
      4'd2:                   cur_byte = b2;
      4'(CRC_LEN):            cur_byte = crc_inv[15:8];
      4'(FRAME_LEN - 1):      cur_byte = crc_inv[7:0];
      default:                cur_byte = 8'h00;
    endcase
    word.valid = start || busy;
    word.data  = start ? cmd_code : cur_byte;
    word.last  = !start && (idx == 4'(FRAME_LEN - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 4'd0;
    end else if (start) begin
      busy <= 1'b1;
      idx  <= 4'd1;
      b1   <= b1_next;
      b2   <= b2_next;
      crc  <= crc_byte(CRC_INIT, cmd_code);
    end else if (busy && advance) begin
      idx <= idx + 4'd1;
      if (idx < 4'(CRC_LEN)) begin
        crc <= crc_byte(crc, cur_byte);
      end
      if (idx == 4'(FRAME_LEN - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/ifc_rx.sv
module ifc_rx (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         rx_byte,
  output ifc_pkg::rx_report_t report
);
  import ifc_pkg::*;

  logic [3:0]  count;
  logic [15:0] crc;
  logic [7:0]  frame [CRC_LEN + 1];
  logic [15:0] held_rpm;
  logic [7:0]  held_fault;
  logic        complete;
  logic        ok;
  logic [15:0] frame_rpm;

  // The tenth byte is the CRC low byte and is used straight from the input.
  assign complete  = (count == 4'(FRAME_LEN - 1));
  assign ok        = (~crc == {frame[CRC_LEN], rx_byte});
  assign frame_rpm = {frame[2], frame[3]};

  always_comb begin
    report.valid       = take && complete;
    report.crc_ok      = ok;
    report.echoed_mode = frame[1];
    if (frame[0] == REPLY_ACK) begin
      report.reply_kind = RK_ACK;
    end else if (frame[0] == REPLY_NCK) begin
      report.reply_kind = RK_NCK;
    end else begin
      report.reply_kind = RK_OTHER;
    end
    report.motor_rpm  = ok ? frame_rpm : held_rpm;
    report.fault_code = ok ? frame[5] : held_fault;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= 4'd0;
      crc        <= CRC_INIT;
      held_rpm   <= 16'h0000;
      held_fault <= 8'h00;
    end else if (take) begin
      if (complete) begin
        count <= 4'd0;
        crc   <= CRC_INIT;
        if (ok) begin
          held_rpm   <= frame_rpm;
          held_fault <= frame[5];
        end
      end else begin
        count <= count + 4'd1;
        if (count < 4'(CRC_LEN)) begin
          crc <= crc_byte(crc, rx_byte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !complete) begin
      frame[count] <= rx_byte;
    end
  end

endmodule

FILE: rtl/inverter_frame_codec_crc16.sv
// Framed command link codec for a motor inverter, CRC-16/X-25 protected.
// Input channel (in_valid/in_ready): one word is either a send request
// (action 0: cmd_code, speed_value, accel_value) or one received link byte
// (action 1: rx_byte). Output channel (out_valid/out_ready): transmit bytes
// (kind 0) and frame reports (kind 1), each from one output register.
// A send yields ten transmit bytes, one per cycle while the receiver takes
// them; byte 0 appears in the cycle after acceptance, and the next word
// can be taken in the cycle after byte 9 is loaded. The serializer runs
// one CRC byte step per cycle while the output advances, over bytes 0 to
// 7. Every tenth received byte yields a report in the next cycle, and none
// for the other nine. Receive bytes can be taken every cycle while no send
// is serialized and the output register is free or being drained. When the
// receiver stalls, the output word holds and in_ready drops until the
// output register frees up. Reset clears the frame counter, receive CRC,
// held speed and fault, and empties the output register.
module inverter_frame_codec_crc16 (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [7:0]  cmd_code,
  input  logic [15:0] speed_value,
  input  logic [7:0]  accel_value,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [7:0]  tx_byte,
  output logic        last,
  output logic        crc_ok,
  output logic [1:0]  reply_kind,
  output logic [7:0]  echoed_mode,
  output logic [15:0] motor_rpm,
  output logic [7:0]  fault_code
);
  import ifc_pkg::*;

  `include "inverter_frame_codec_crc16_macros.svh"

  logic       out_free;
  logic       in_fire;
  logic       start;
  logic       take;
  logic       tx_busy;
  tx_word_t   tx_word;
  rx_report_t rx_rep;

  assign out_free = !out_valid || out_ready;
  assign in_ready = out_free && !tx_busy;
  assign in_fire  = in_valid && in_ready;
  assign start    = in_fire && (action == ACTION_SEND);
  assign take     = in_fire && (action == ACTION_RECV);

  ifc_tx u_tx (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .advance     (out_free),
    .cmd_code    (cmd_code),
    .speed_value (speed_value),
    .accel_value (accel_value),
    .word        (tx_word),
    .busy        (tx_busy)
  );

  ifc_rx u_rx (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx_byte),
    .report  (rx_rep)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= tx_word.valid || rx_rep.valid;
    end
  end

  // A report and a transmit byte never compete: a receive is only taken
  // while the serializer is idle.
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (rx_rep.valid) begin
        kind        <= KIND_REPORT;
        tx_byte     <= 8'h00;
        last        <= 1'b1;
        crc_ok      <= rx_rep.crc_ok;
        reply_kind  <= rx_rep.reply_kind;
        echoed_mode <= rx_rep.echoed_mode;
        motor_rpm   <= rx_rep.motor_rpm;
        fault_code  <= rx_rep.fault_code;
      end else begin
        kind        <= KIND_TX;
        tx_byte     <= tx_word.data;
        last        <= tx_word.last;
        crc_ok      <= 1'b0;
        reply_kind  <= 2'd0;
        echoed_mode <= 8'h00;
        motor_rpm   <= 16'h0000;
        fault_code  <= 8'h00;
      end
    end
  end

  `IFC_ASSERT_NEXT(a_send_busy, start, tx_busy)
  `IFC_ASSERT_SAME(a_last_tx_idle, out_valid && kind == KIND_TX && last, !tx_busy)
  `IFC_ASSERT_SAME(a_report_shape, out_valid && kind == KIND_REPORT, last && tx_byte == 8'h00)

endmodule

FILE: dv/testbench.sv
module testbench;
  import ifc_pkg::*;

  localparam int RUN_LIMIT = 200000;
  localparam int PHASE_WORDS = 45;
  localparam int SHOWN_MISMATCHES = 10;
  localparam int TAIL_CYCLES = 30;

  typedef struct packed {
    logic        action;
    logic [7:0]  cmd;
    logic [15:0] speed;
    logic [7:0]  accel;
    logic [7:0]  rxb;
  } link_word_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic        crc_ok;
    reply_kind_t reply_kind;
    logic [7:0]  echoed_mode;
    logic [15:0] motor_rpm;
    logic [7:0]  fault_code;
  } link_result_t;

  typedef struct {
    link_word_t   word;
    bit           typed;
    link_result_t report;
  } directed_row_t;

  typedef logic [0:FRAME_LEN-1][7:0] frame_bytes_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action = 1'b0;
  logic [7:0]  cmd_code = '0;
  logic [15:0] speed_value = '0;
  logic [7:0]  accel_value = '0;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic        crc_ok;
  logic [1:0]  reply_kind;
  logic [7:0]  echoed_mode;
  logic [15:0] motor_rpm;
  logic [7:0]  fault_code;

  // Output words owed by the codec, oldest first.
  link_result_t owed_words[$];
  directed_row_t directed_rows[$];

  // Mirror of the receive side of the link.
  int unsigned  rx_fill = 0;
  logic [15:0]  rx_sum = CRC_INIT;
  frame_bytes_t rx_bytes;
  logic [15:0]  good_rpm = '0;
  logic [7:0]   good_fault = '0;

  int          idle_pct = 0;
  int          stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned words_taken = 0;
  int unsigned sends_taken = 0;
  int unsigned tx_seen = 0;
  int unsigned reports_seen = 0;
  int unsigned bad_crc_seen = 0;
  int unsigned mismatch_count = 0;

  inverter_frame_codec_crc16 dut (
    .clk, .rst, .in_valid, .in_ready, .action, .cmd_code, .speed_value,
    .accel_value, .rx_byte, .out_valid, .out_ready, .kind, .tx_byte, .last,
    .crc_ok, .reply_kind, .echoed_mode, .motor_rpm, .fault_code
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bit-serial reflected CRC step; gives the same result as the nibble table.
  function automatic logic [15:0] x25_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    int i;
    r = c;
    for (i = 0; i < 8; i++) begin
      if (r[0] ^ b[i]) r = (r >> 1) ^ 16'h8408;
      else r = r >> 1;
    end
    return r;
  endfunction

  function automatic logic [15:0] frame_seal(input frame_bytes_t fr);
    logic [15:0] c;
    int k;
    c = CRC_INIT;
    for (k = 0; k < CRC_LEN; k++) c = x25_byte(c, fr[k]);
    return ~c;
  endfunction

  function automatic link_word_t make_send(input logic [7:0] cmd, input logic [15:0] spd,
                                           input logic [7:0] acc);
    link_word_t w;
    w.action = ACTION_SEND;
    w.cmd = cmd;
    w.speed = spd;
    w.accel = acc;
    w.rxb = 8'($urandom);
    return w;
  endfunction

  function automatic link_word_t make_rx(input logic [7:0] b);
    link_word_t w;
    w.action = ACTION_RECV;
    w.cmd = 8'($urandom);
    w.speed = 16'($urandom);
    w.accel = 8'($urandom);
    w.rxb = b;
    return w;
  endfunction

  function automatic string show_word(input link_result_t r);
    return {$sformatf("kind %0d byte %02h last %0d crc_ok %0d ",
                      r.kind, r.tx_byte, r.last, r.crc_ok),
            $sformatf("reply %0d mode %02h rpm %04h fault %02h",
                      r.reply_kind, r.echoed_mode, r.motor_rpm, r.fault_code)};
  endfunction

  // Works out what one accepted word makes the codec emit.
  task automatic apply_link_word(input link_word_t w);
    frame_bytes_t fr;
    logic [15:0] seal;
    link_result_t r;
    int k;
    if (w.action == ACTION_SEND) begin
      fr = '0;
      fr[0] = w.cmd;
      if (w.cmd == CMD_CW || w.cmd == CMD_CCW) begin
        fr[1] = w.speed[15:8];
        fr[2] = w.speed[7:0];
      end else if (w.cmd == CMD_ACCEL) begin
        fr[1] = w.accel;
      end
      seal = frame_seal(fr);
      fr[CRC_LEN] = seal[15:8];
      fr[CRC_LEN+1] = seal[7:0];
      for (k = 0; k < FRAME_LEN; k++) begin
        r = '0;
        r.kind = KIND_TX;
        r.tx_byte = fr[k];
        r.last = (k == FRAME_LEN - 1);
        owed_words.push_back(r);
      end
      sends_taken++;
    end else begin
      rx_bytes[rx_fill] = w.rxb;
      if (rx_fill < CRC_LEN) rx_sum = x25_byte(rx_sum, w.rxb);
      rx_fill++;
      if (rx_fill == FRAME_LEN) begin
        seal = ~rx_sum;
        r = '0;
        r.kind = KIND_REPORT;
        r.last = 1'b1;
        r.crc_ok = (seal == {rx_bytes[CRC_LEN], rx_bytes[CRC_LEN+1]});
        // A frame with a bad CRC leaves the held speed and fault alone.
        if (r.crc_ok) begin
          good_rpm = {rx_bytes[2], rx_bytes[3]};
          good_fault = rx_bytes[5];
        end
        if (rx_bytes[0] == REPLY_ACK) r.reply_kind = RK_ACK;
        else if (rx_bytes[0] == REPLY_NCK) r.reply_kind = RK_NCK;
        else r.reply_kind = RK_OTHER;
        r.echoed_mode = rx_bytes[1];
        r.motor_rpm = good_rpm;
        r.fault_code = good_fault;
        owed_words.push_back(r);
        rx_fill = 0;
        rx_sum = CRC_INIT;
      end
    end
  endtask

  // Offers one word and returns at the edge where it is taken. Valid is only
  // lowered when a gap is inserted, so back-to-back words keep it high.
  task automatic put_word(input link_word_t w);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    action <= w.action;
    cmd_code <= w.cmd;
    speed_value <= w.speed;
    accel_value <= w.accel;
    rx_byte <= w.rxb;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    apply_link_word(w);
    words_taken++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_words.size() != 0);
  endtask

  task automatic put_random_send();
    logic [7:0] cmd;
    logic [15:0] spd;
    case ($urandom_range(3))
      0: cmd = CMD_CW;
      1: cmd = CMD_CCW;
      2: cmd = CMD_ACCEL;
      default: cmd = 8'($urandom);
    endcase
    case ($urandom_range(9))
      0: spd = '0;
      1: spd = '1;
      default: spd = 16'($urandom);
    endcase
    put_word(make_send(cmd, spd, 8'($urandom)));
  endtask

  // A well-formed reply frame with random content; one in five gets a single
  // flipped bit, and sends are sprinkled between its bytes.
  task automatic put_random_frame();
    frame_bytes_t fr;
    logic [15:0] seal;
    int k;
    int pos;
    for (k = 0; k < FRAME_LEN; k++) fr[k] = 8'($urandom);
    case ($urandom_range(2))
      0: fr[0] = REPLY_ACK;
      1: fr[0] = REPLY_NCK;
      default: ;
    endcase
    seal = frame_seal(fr);
    fr[CRC_LEN] = seal[15:8];
    fr[CRC_LEN+1] = seal[7:0];
    if ($urandom_range(4) == 0) begin
      pos = $urandom_range(FRAME_LEN - 1);
      fr[pos] = fr[pos] ^ (8'h01 << $urandom_range(7));
    end
    for (k = 0; k < FRAME_LEN; k++) begin
      if ($urandom_range(9) == 0) put_random_send();
      put_word(make_rx(fr[k]));
    end
  endtask

  task automatic add_row(input link_word_t w, input bit typed, input link_result_t rep);
    directed_row_t row;
    row.word = w;
    row.typed = typed;
    row.report = rep;
    directed_rows.push_back(row);
  endtask

  always @(posedge clk) begin
    out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // Outputs are sampled at the falling edge before the rising edge that takes them.
  always @(negedge clk) begin
    link_result_t got;
    link_result_t want;
    if (!rst && out_valid && out_ready) begin
      got.kind = kind;
      got.tx_byte = tx_byte;
      got.last = last;
      got.crc_ok = crc_ok;
      got.reply_kind = reply_kind_t'(reply_kind);
      got.echoed_mode = echoed_mode;
      got.motor_rpm = motor_rpm;
      got.fault_code = fault_code;
      if (got.kind == KIND_TX) begin
        tx_seen++;
      end else begin
        reports_seen++;
        if (!got.crc_ok) bad_crc_seen++;
      end
      if (owed_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOWN_MISMATCHES)
          $display("Output word with nothing owed: %s", show_word(got));
      end else begin
        want = owed_words.pop_front();
        if (got.kind !== want.kind || got.tx_byte !== want.tx_byte ||
            got.last !== want.last || got.crc_ok !== want.crc_ok ||
            got.reply_kind !== want.reply_kind || got.echoed_mode !== want.echoed_mode ||
            got.motor_rpm !== want.motor_rpm || got.fault_code !== want.fault_code) begin
          mismatch_count++;
          if (mismatch_count <= SHOWN_MISMATCHES) begin
            $display("Output word mismatch at cycle %0d", cycle_count);
            $display("  expected %s", show_word(want));
            $display("  actual   %s", show_word(got));
          end
        end
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("Run stopped at the cycle limit with %0d output words still owed.",
             owed_words.size());
    $display("FAIL inverter_frame_codec_crc16");
    $finish;
  end

  initial begin
    frame_bytes_t fr;
    logic [15:0] seal;
    link_result_t nck_report;
    link_result_t ack_report;
    int k;
    int phase;
    int unsigned phase_start;

    // Sends at the extremes of speed and acceleration, and an unknown command
    // whose payload must come out all zero.
    add_row(make_send(CMD_CW, 16'hFFFF, 8'h00), 1'b0, '0);
    add_row(make_send(CMD_CCW, 16'h0000, 8'hFF), 1'b0, '0);
    add_row(make_send(CMD_ACCEL, 16'hFFFF, 8'hFF), 1'b0, '0);
    add_row(make_send(8'h00, 16'hFFFF, 8'hFF), 1'b0, '0);

    // A nck frame with a corrupted CRC right after reset: the held speed and
    // fault are still zero. A send lands in the middle of it.
    fr = '1;
    fr[0] = REPLY_NCK;
    seal = frame_seal(fr);
    fr[CRC_LEN] = seal[15:8];
    fr[CRC_LEN+1] = seal[7:0] ^ 8'h01;
    nck_report = '{KIND_REPORT, 8'h00, 1'b1, 1'b0, RK_NCK, 8'hFF, 16'h0000, 8'h00};
    for (k = 0; k < FRAME_LEN; k++) begin
      add_row(make_rx(fr[k]), k == FRAME_LEN - 1, nck_report);
      if (k == 4) add_row(make_send(8'hFF, 16'hFFFF, 8'hFF), 1'b0, '0);
    end

    // A clean ack frame carrying all-ones speed and fault.
    fr = '0;
    fr[0] = REPLY_ACK;
    fr[2] = 8'hFF;
    fr[3] = 8'hFF;
    fr[5] = 8'hFF;
    seal = frame_seal(fr);
    fr[CRC_LEN] = seal[15:8];
    fr[CRC_LEN+1] = seal[7:0];
    ack_report = '{KIND_REPORT, 8'h00, 1'b1, 1'b1, RK_ACK, 8'h00, 16'hFFFF, 8'hFF};
    for (k = 0; k < FRAME_LEN; k++)
      add_row(make_rx(fr[k]), k == FRAME_LEN - 1, ack_report);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      put_word(directed_rows[i].word);
      if (directed_rows[i].typed)
        owed_words[owed_words.size() - 1] = directed_rows[i].report;
    end
    wait_drained();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 51; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 51; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      phase_start = words_taken;
      while (words_taken - phase_start < PHASE_WORDS) begin
        if ($urandom_range(9) < 3) put_random_send();
        else put_random_frame();
      end
      // Hold the sender back until everything owed has come out.
      wait_drained();
    end

    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run took %0d words (%0d sends) under four idle and stall mixes.",
             words_taken, sends_taken);
    $display("Checked %0d transmit bytes and %0d frame reports, %0d of them with a bad CRC.",
             tx_seen, reports_seen, bad_crc_seen);
    if (mismatch_count == 0 && owed_words.size() == 0) begin
      $display("PASS inverter_frame_codec_crc16");
    end else begin
      $display("FAIL inverter_frame_codec_crc16");
    end
    $finish;
  end

endmodule
